// ----- rtl/rfr_pkg.sv -----
package rfr_pkg;

  // Fixed field widths
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned FRAME_W      = 56;
  localparam int unsigned CLASS_W      = 2;
  localparam int unsigned FRAME_LEN_DEF = 7;

  // Frame and command marks
  localparam logic [BYTE_W-1:0] START_MARK   = 8'h7D;
  localparam logic [BYTE_W-1:0] CMD_MARK     = 8'h7E;
  localparam logic [BYTE_W-1:0] TYPE_CURTAIN = 8'h32;
  localparam logic [BYTE_W-1:0] TYPE_AIRCON  = 8'h33;

  // Item kinds
  localparam logic MODE_RX = 1'b0;
  localparam logic MODE_TX = 1'b1;

  // Device class codes
  localparam logic [CLASS_W-1:0] CLASS_CURTAIN = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_AIRCON  = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_UNKNOWN = 2'd2;

  typedef struct packed {
    logic              mode;
    logic [BYTE_W-1:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_bytes;
    logic               checksum_ok;
    logic [CLASS_W-1:0] device_class;
  } result_t;

  // Map the type byte to a device class
  function automatic logic [CLASS_W-1:0] class_of(input logic [BYTE_W-1:0] type_byte);
    logic [CLASS_W-1:0] cls;
    case (type_byte)
      TYPE_CURTAIN: cls = CLASS_CURTAIN;
      TYPE_AIRCON:  cls = CLASS_AIRCON;
      default:      cls = CLASS_UNKNOWN;
    endcase
    return cls;
  endfunction

endpackage

// ----- rtl/rfr_input_stage.sv -----
module rfr_input_stage
  import rfr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_ready,
  input  item_t item,
  output logic  stage_valid,
  output item_t stage_item,
  input  logic  stage_take
);

  // Accept a new transaction when the register is empty or drains this cycle
  assign item_ready = !stage_valid || stage_take;

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  // Capture the payload
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      stage_item <= item;
    end
  end

endmodule

// ----- rtl/rfr_frame_engine.sv -----
module rfr_frame_engine
  import rfr_pkg::*;
#(
  parameter int unsigned FRAME_LEN = FRAME_LEN_DEF
)(
  input  logic    clk,
  input  logic    rst,
  input  logic    stage_valid,
  input  item_t   stage_item,
  output logic    stage_take,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  localparam int unsigned CNT_W = $clog2(FRAME_LEN);
  localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(FRAME_LEN - 1);

  logic [CNT_W-1:0]   byte_count;
  logic [CNT_W-1:0]   byte_count_next;
  logic [BYTE_W-1:0]  last_command;
  logic [FRAME_W-1:0] frame_shift;
  logic [FRAME_W-1:0] frame_shift_next;
  logic [BYTE_W-1:0]  run_sum;
  logic [BYTE_W-1:0]  run_sum_next;
  logic [BYTE_W-1:0]  type_byte;
  logic [BYTE_W-1:0]  rx_byte;
  logic               is_rx;
  logic               byte_ok;
  logic               at_first;
  logic               at_last;
  logic               frame_done;

  // Advance when the result register is free or emptying
  assign stage_take = stage_valid && (!result_valid || result_ready);

  // Decide on the byte in the input register
  always_comb begin
    rx_byte    = stage_item.data_byte;
    is_rx      = (stage_item.mode == MODE_RX);
    at_first   = (byte_count == '0);
    at_last    = (byte_count == LAST_POS);
    byte_ok    = (at_first ? (rx_byte == START_MARK) : 1'b1) && (last_command == CMD_MARK);
    frame_done = stage_take && is_rx && byte_ok && at_last;

    byte_count_next = byte_count;
    if (is_rx) begin
      if (!byte_ok || at_last) begin
        byte_count_next = '0;
      end else begin
        byte_count_next = byte_count + 1'b1;
      end
    end

    if (at_first) begin
      frame_shift_next = {{(FRAME_W-BYTE_W){1'b0}}, rx_byte};
      run_sum_next     = rx_byte;
    end else begin
      frame_shift_next = {frame_shift[FRAME_W-BYTE_W-1:0], rx_byte};
      run_sum_next     = run_sum + rx_byte;
    end
  end

  // Hold control state and the result flag
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      last_command <= '0;
      result_valid <= 1'b0;
    end else begin
      if (frame_done) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      if (stage_take) begin
        if (!is_rx) begin
          last_command <= rx_byte;
        end
        byte_count <= byte_count_next;
      end
    end
  end

  // Collect frame bytes, running sum and type byte; load the result when a frame completes
  always_ff @(posedge clk) begin
    if (stage_take && is_rx && byte_ok) begin
      frame_shift <= frame_shift_next;
      run_sum     <= run_sum_next;
      if (byte_count == CNT_W'(1)) begin
        type_byte <= rx_byte;
      end
    end
    if (frame_done) begin
      result.frame_bytes  <= frame_shift_next;
      result.checksum_ok  <= (run_sum == rx_byte);
      result.device_class <= class_of(type_byte);
    end
  end

  // Count never runs past the last position
  assert property (@(posedge clk) disable iff (rst) byte_count <= LAST_POS)
    else $error("byte count out of range");

  // A transmitted command byte leaves the count alone
  assert property (@(posedge clk) disable iff (rst)
    stage_take && !is_rx |=> $stable(byte_count))
    else $error("command byte moved the count");

  // A new result only follows a byte at the last position
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(at_last) && $past(last_command) == CMD_MARK)
    else $error("result without a complete frame");

  // A completed frame always restarts collection
  assert property (@(posedge clk) disable iff (rst)
    frame_done |=> byte_count == '0 && result_valid)
    else $error("frame completion not handled");

endmodule

// ----- rtl/rs485_frame_receiver_core.sv -----
// Channel  Valid         Ready         Payload
// item     item_valid    item_ready    item   (mode, data_byte)
// result   result_valid  result_ready  result (frame_bytes, checksum_ok, device_class)
//
// One item per cycle while no result waits; a frame's result is registered as the engine
// takes its last byte. Each byte passes an input register, then one pass of compare, add
// and shift into the result register; a running sum keeps the per-byte logic short.
// Reset (rst, synchronous) clears the byte count, last command and both valid flags.
// A waiting result stalls the engine; the input register takes one more item, then
// item_ready drops until the result is taken.
module rs485_frame_receiver_core
  import rfr_pkg::*;
#(
  parameter int unsigned FRAME_LEN = FRAME_LEN_DEF
)(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  logic  stage_valid;
  item_t stage_item;
  logic  stage_take;

  rfr_input_stage u_input (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .stage_valid (stage_valid),
    .stage_item  (stage_item),
    .stage_take  (stage_take)
  );

  rfr_frame_engine #(
    .FRAME_LEN (FRAME_LEN)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .stage_valid  (stage_valid),
    .stage_item   (stage_item),
    .stage_take   (stage_take),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ----- verif/rs485_frame_receiver_core_tb.sv -----
`timescale 1ns / 100ps

module rs485_frame_receiver_core_tb;
  import rfr_pkg::*;

  localparam int unsigned FRAME_LEN = FRAME_LEN_DEF;
  localparam int unsigned STALL_LEN = 300;

  // One frame, byte 0 in the most significant position
  typedef logic [0:FRAME_LEN-1][BYTE_W-1:0] frame_t;

  logic    clk;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  logic        stall_go = 1'b0;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned items_sent = 0;
  int unsigned error_count = 0;

  // Predicted receiver state
  logic [BYTE_W-1:0] frame_copy [FRAME_LEN];
  int unsigned       held_count = 0;
  logic [BYTE_W-1:0] tx_command = '0;
  result_t           expected_frames [$];

  rs485_frame_receiver_core #(.FRAME_LEN(FRAME_LEN)) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_frame_copy();
    foreach (frame_copy[i]) frame_copy[i] = '0;
    held_count = 0;
  endfunction

  // Advance the predicted state by one accepted transaction
  function automatic void predict_item(item_t it);
    logic [FRAME_W-1:0] frame_word;
    logic [BYTE_W-1:0]  sum;
    result_t            res;
    if (it.mode == MODE_TX) begin
      tx_command = it.data_byte;
    end else begin
      if (held_count >= FRAME_LEN) held_count = 0;
      frame_copy[held_count] = it.data_byte;
      if (frame_copy[0] != START_MARK || tx_command != CMD_MARK) begin
        clear_frame_copy();
      end else begin
        held_count++;
        if (held_count == FRAME_LEN) begin
          frame_word = '0;
          sum = '0;
          for (int i = 0; i < FRAME_LEN; i++) begin
            frame_word = {frame_word[FRAME_W-BYTE_W-1:0], frame_copy[i]};
            if (i < FRAME_LEN - 1) sum += frame_copy[i];
          end
          res.frame_bytes = frame_word;
          res.checksum_ok = (sum == frame_copy[FRAME_LEN-1]);
          if (frame_copy[1] == TYPE_CURTAIN) res.device_class = CLASS_CURTAIN;
          else if (frame_copy[1] == TYPE_AIRCON) res.device_class = CLASS_AIRCON;
          else res.device_class = CLASS_UNKNOWN;
          expected_frames.push_back(res);
          clear_frame_copy();
        end
      end
    end
  endfunction

  // Offer one transaction after a random gap and wait for acceptance
  task automatic send_item(input logic mode, input logic [BYTE_W-1:0] data);
    item_t it;
    it.mode      = mode;
    it.data_byte = data;
    while ($urandom_range(99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (!item_ready);
    predict_item(it);
    items_sent++;
  endtask

  // Send a frame; put a fresh start command in front of byte cmd_at
  task automatic send_rx_frame(input frame_t fb, input int unsigned cmd_at);
    for (int i = 0; i < FRAME_LEN; i++) begin
      if (i == cmd_at) send_item(MODE_TX, CMD_MARK);
      send_item(MODE_RX, fb[i]);
    end
  endtask

  function automatic frame_t random_frame();
    frame_t            fb;
    logic [BYTE_W-1:0] sum;
    fb[0] = START_MARK;
    case ($urandom_range(2))
      0: fb[1] = TYPE_CURTAIN;
      1: fb[1] = TYPE_AIRCON;
      default: fb[1] = BYTE_W'($urandom_range(255));
    endcase
    sum = fb[0] + fb[1];
    for (int i = 2; i < FRAME_LEN - 1; i++) begin
      fb[i] = BYTE_W'($urandom_range(255));
      sum += fb[i];
    end
    // Mostly a correct checksum, sometimes a random one
    fb[FRAME_LEN-1] = ($urandom_range(3) == 0) ? BYTE_W'($urandom_range(255)) : sum;
    return fb;
  endfunction

  // Drop any partial frame and make sure the start command is in place
  task automatic start_clean();
    if (held_count != 0) begin
      send_item(MODE_TX, 8'h00);
      send_item(MODE_RX, 8'h00);
    end
    if (tx_command != CMD_MARK) send_item(MODE_TX, CMD_MARK);
  endtask

  task automatic test_directed_frames();
    // Line byte before any command: rejected
    send_item(MODE_RX, START_MARK);
    send_item(MODE_TX, CMD_MARK);
    // Curtain frame, good checksum
    send_rx_frame({START_MARK, TYPE_CURTAIN, 8'h00, 8'h00, 8'h00, 8'h00, 8'hAF},
                  FRAME_LEN);
    // Wrong start byte: rejected
    send_item(MODE_RX, 8'h7C);
    // Aircon frame, all-ones body, bad checksum
    send_rx_frame({START_MARK, TYPE_AIRCON, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00},
                  FRAME_LEN);
    // Command moves away inside a frame: next line byte rejected
    send_item(MODE_RX, START_MARK);
    send_item(MODE_TX, 8'hFF);
    send_item(MODE_RX, 8'h55);
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned keep;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        // Well-formed frame, now and then misaligned or with a repeated command
        if ($urandom_range(7) != 0) start_clean();
        if ($urandom_range(3) == 0) send_item(MODE_TX, CMD_MARK);
        send_rx_frame(random_frame(),
                      ($urandom_range(9) == 0) ? $urandom_range(FRAME_LEN - 1, 1)
                                               : FRAME_LEN);
      end else if (pick < 80) begin
        // Truncated frame, then a different command and a rejected byte
        start_clean();
        send_item(MODE_RX, START_MARK);
        keep = $urandom_range(FRAME_LEN - 2);
        repeat (keep) send_item(MODE_RX, BYTE_W'($urandom_range(255)));
        send_item(MODE_TX, BYTE_W'($urandom_range(CMD_MARK - 1)));
        send_item(MODE_RX, BYTE_W'($urandom_range(255)));
      end else if (pick < 90) begin
        send_item(MODE_RX, BYTE_W'($urandom_range(255)));
      end else begin
        send_item(MODE_TX, BYTE_W'($urandom_range(255)));
      end
    end
  endtask

  // Hold off the result side while frames keep coming, so the input stalls
  task automatic test_backpressure();
    item_valid <= 1'b0;
    stall_go   <= 1'b1;
    @(posedge clk);
    stall_go <= 1'b0;
    start_clean();
    repeat (4) send_rx_frame(random_frame(), FRAME_LEN);
  endtask

  // Drive result_ready: random stalls, or one long hold on request
  initial begin : drive_result_ready
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_go) stall_left = STALL_LEN;
      if (stall_left > 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Compare each result transaction with the oldest predicted frame
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_frames.size() == 0) begin
        $error("result with no frame expected: %h", result);
        error_count++;
      end else begin
        want = expected_frames.pop_front();
        if (result.frame_bytes !== want.frame_bytes) begin
          $error("frame_bytes: expected %h, got %h", want.frame_bytes, result.frame_bytes);
          error_count++;
        end
        if (result.checksum_ok !== want.checksum_ok) begin
          $error("checksum_ok: expected %b, got %b", want.checksum_ok, result.checksum_ok);
          error_count++;
        end
        if (result.device_class !== want.device_class) begin
          $error("device_class: expected %0d, got %0d",
                 want.device_class, result.device_class);
          error_count++;
        end
      end
    end
  end

  initial begin : run_tests
    tx_idle_pct = 6;
    rx_idle_pct <= 51;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_frames();
    test_random_traffic(300);
    tx_idle_pct = 51;
    rx_idle_pct <= 6;
    test_random_traffic(300);
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    test_backpressure();
    test_random_traffic(300);
    item_valid <= 1'b0;
    // Drain outstanding frames, then let the pipeline settle
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
